// File: sv/display_reply_frame_parser_unit_assert.svh
// Assertion macros for the display reply frame parser.
`ifndef DISPLAY_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH
`define DISPLAY_REPLY_FRAME_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRFP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drfp check failed");

// The consequent must hold in the cycle after the antecedent.
`define DRFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drfp check failed");

`endif

// File: sv/drfp_pkg.sv
// Shared constants, tables and types of the display reply frame parser.
`default_nettype none

package drfp_pkg;

  // Header bytes and frame layout.
  localparam logic [7:0] HDR_FIRST    = 8'h5A;
  localparam logic [7:0] HDR_SECOND   = 8'hA5;
  localparam logic [8:0] LEN_EXTRA    = 9'd3;
  localparam logic [8:0] MIN_TOTAL    = 9'd9;
  localparam logic [8:0] ADDR_OFFSET  = 9'd4;
  localparam logic [8:0] VALUE_OFFSET = 9'd8;

  // Register reset value and parameter default.
  localparam logic [7:0] IGNORED_RESET    = 8'h4F;
  localparam int         NUM_SWITCHES_DEF = 9;

  // Known switch addresses, in match order.
  localparam int SWITCH_TABLE = 9;
  localparam logic [7:0] SWITCH_ADDR [SWITCH_TABLE] = '{
    8'h65, 8'h66, 8'h67, 8'h55, 8'h56, 8'h45, 8'h46, 8'h47, 8'h68
  };

  // Header hunt and frame body phases.
  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_LEN,
    PH_BODY
  } phase_t;

  // Frame completion report from the tracker to the switch table.
  typedef struct packed {
    logic       done;
    logic       total_ok;
    logic [7:0] address;
    logic [7:0] value;
  } frame_end_t;

endpackage

`default_nettype wire

// File: sv/display_reply_frame_parser_unit.sv
// Top level of the display reply frame parser.
`default_nettype none

`include "display_reply_frame_parser_unit_assert.svh"

// Accepts one received byte per cycle unless the result side stalls, and
// reports one request for every complete frame 5A A5 L ... of L+3 bytes
// whose length is at least 6 and whose address is not the ignored address.
// A byte goes through an input register, is parsed combinationally by the
// frame tracker and switch lookup, and a finished frame lands in the result
// register, from which it is offered. The sustained rate is one byte per
// cycle while the result register is not stalled, set by the tracker state
// taking a byte on every step; a stalled result register holds the parse
// stage and in turn the input. There is no clearing pass after reset.
module display_reply_frame_parser_unit
  import drfp_pkg::*;
#(
  parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_enable,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      frame_address,
  output logic [7:0]      frame_value,
  output logic            is_switch,
  output logic [3:0]      switch_number,
  output logic            switch_changed
);

  localparam int LIMIT = (NUM_SWITCHES < SWITCH_TABLE) ? NUM_SWITCHES : SWITCH_TABLE;

  logic       ignored_address;
  logic [7:0] ignored_reg;
  logic       s_valid;
  logic [7:0] s_byte;
  logic       advance;
  logic       step;
  logic       commit;
  frame_end_t frame_end;
  logic       sw_match;
  logic [3:0] sw_number;
  logic       sw_changed;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) ignored_reg <= IGNORED_RESET;
    else if (cfg_write_enable) ignored_reg <= cfg_write_data;
  end

  // The parse stage moves whenever the result register can take a result.
  assign advance  = !out_valid || out_ready;
  assign step     = s_valid && advance;
  assign in_ready = !s_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s_byte <= rx_byte;
  end

  drfp_frame_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (s_byte),
    .frame_end (frame_end)
  );

  // A finished frame is kept unless it is short or names the ignored address.
  assign ignored_address = (frame_end.address == ignored_reg);
  assign commit = frame_end.done && frame_end.total_ok && !ignored_address;

  drfp_switch_table #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_switches (
    .clk            (clk),
    .rst            (rst),
    .commit         (commit),
    .address        (frame_end.address),
    .value          (frame_end.value),
    .is_switch      (sw_match),
    .switch_number  (sw_number),
    .switch_changed (sw_changed)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      frame_address  <= frame_end.address;
      frame_value    <= frame_end.value;
      is_switch      <= sw_match;
      switch_number  <= sw_number;
      switch_changed <= sw_changed;
    end
  end

  // Checks on the parse and result stages.
  `DRFP_ASSERT_SAME(a_no_switch_fields, out_valid && !is_switch,
                    switch_number == 4'd0 && !switch_changed)
  `DRFP_ASSERT_SAME(a_number_range, out_valid && is_switch,
                    {28'd0, switch_number} < 32'(LIMIT))
  `DRFP_ASSERT_NEXT(a_stage_holds, s_valid && !advance,
                    s_valid && $stable(s_byte))
  `DRFP_ASSERT_SAME(a_commit_has_room, commit, advance)

endmodule

`default_nettype wire

// File: sv/drfp_frame_tracker.sv
// Header hunt, length tracking and field capture for one byte per step.
`default_nettype none

module drfp_frame_tracker
  import drfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output frame_end_t      frame_end
);

  phase_t     phase, phase_next;
  logic [8:0] position, position_next;
  logic [8:0] total, total_next;
  logic [7:0] address, address_next;
  logic [7:0] value, value_next;
  logic [8:0] len_total;
  logic [8:0] position_inc;

  assign len_total    = {1'b0, rx_byte} + LEN_EXTRA;
  assign position_inc = position + 9'd1;

  // Next phase of the header hunt and frame body.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HDR1: begin
        if (rx_byte == HDR_FIRST) phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        if (rx_byte == HDR_SECOND) phase_next = PH_LEN;
        else if (rx_byte != HDR_FIRST) phase_next = PH_HDR1;
      end
      PH_LEN: begin
        // A zero length ends the frame at the length byte.
        if (len_total <= LEN_EXTRA) phase_next = PH_HDR1;
        else phase_next = PH_BODY;
      end
      PH_BODY: begin
        if (position_inc >= total) phase_next = PH_HDR1;
      end
      default: phase_next = PH_HDR1;
    endcase
  end

  // Counters, captured fields and the end-of-frame report.
  always_comb begin
    position_next      = position;
    total_next         = total;
    address_next       = address;
    value_next         = value;
    frame_end          = '0;
    unique case (phase)
      PH_LEN: begin
        total_next         = len_total;
        position_next      = LEN_EXTRA;
        address_next       = '0;
        value_next         = '0;
        frame_end.done     = (len_total <= LEN_EXTRA);
        frame_end.total_ok = (len_total >= MIN_TOTAL);
      end
      PH_BODY: begin
        if (position == ADDR_OFFSET) address_next = rx_byte;
        if (position == VALUE_OFFSET) value_next = rx_byte;
        frame_end.done     = (position_inc >= total);
        frame_end.total_ok = (total >= MIN_TOTAL);
        position_next      = frame_end.done ? 9'd0 : position_inc;
      end
      default: begin
      end
    endcase
    if (phase == PH_HDR1 || phase == PH_HDR2) position_next = position;
    frame_end.address = address_next;
    frame_end.value   = value_next;
    frame_end.done    = frame_end.done & step;
  end

  // State registers advance only when a byte is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HDR1;
      position <= '0;
      total    <= '0;
      address  <= '0;
      value    <= '0;
    end else if (step) begin
      phase    <= phase_next;
      position <= position_next;
      total    <= total_next;
      address  <= address_next;
      value    <= value_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/drfp_switch_table.sv
// Switch address lookup and per-switch last-value store.
`default_nettype none

module drfp_switch_table
  import drfp_pkg::*;
#(
  parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       commit,
  input  wire logic [7:0] address,
  input  wire logic [7:0] value,
  output logic            is_switch,
  output logic [3:0]      switch_number,
  output logic            switch_changed
);

  localparam int LIMIT = (NUM_SWITCHES < SWITCH_TABLE) ? NUM_SWITCHES : SWITCH_TABLE;

  logic [7:0] last_value [LIMIT];
  logic [LIMIT-1:0] hit;

  // First matching switch address wins.
  always_comb begin
    is_switch      = 1'b0;
    switch_number  = '0;
    switch_changed = 1'b0;
    hit            = '0;
    for (int i = 0; i < LIMIT; i++) begin
      if (!is_switch && address == SWITCH_ADDR[i]) begin
        is_switch      = 1'b1;
        switch_number  = 4'(i);
        switch_changed = (last_value[i] != value);
        hit[i]         = 1'b1;
      end
    end
  end

  // The store takes the new value of a matched switch on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIMIT; i++) last_value[i] <= '0;
    end else if (commit) begin
      for (int i = 0; i < LIMIT; i++) begin
        if (hit[i]) last_value[i] <= value;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/drfp_reply_checker.sv
// Checker for the display reply frame parser: predicts frame results and compares them.
module drfp_reply_checker
  import drfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_enable,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] frame_address,
  input  wire logic [7:0] frame_value,
  input  wire logic       is_switch,
  input  wire logic [3:0] switch_number,
  input  wire logic       switch_changed,
  output int              outstanding,
  output int              failures
);

  // Only the listed switch addresses can ever match.
  localparam int MATCH_LIMIT =
    (NUM_SWITCHES_DEF < SWITCH_TABLE) ? NUM_SWITCHES_DEF : SWITCH_TABLE;

  typedef struct {
    logic [7:0] address;
    logic [7:0] value;
    logic       is_switch;
    logic [3:0] number;
    logic       changed;
  } frame_report_t;

  // Mirror of the parser state and its register.
  phase_t     phase;
  logic [8:0] pos;
  logic [8:0] total;
  logic [7:0] held_addr;
  logic [7:0] held_val;
  logic [7:0] last_value [SWITCH_TABLE];
  logic [7:0] ignored_addr;

  frame_report_t reports_due [$];
  int failure_tally = 0;

  // Ends the current frame and queues its report unless the frame is dropped.
  task close_frame();
    frame_report_t rep;
    int i;
    phase = PH_HDR1;
    pos = '0;
    if (total < MIN_TOTAL || held_addr == ignored_addr) return;
    rep.address = held_addr;
    rep.value = held_val;
    rep.is_switch = 1'b0;
    rep.number = '0;
    rep.changed = 1'b0;
    for (i = 0; i < MATCH_LIMIT; i++) begin
      if (held_addr == SWITCH_ADDR[i]) begin
        rep.is_switch = 1'b1;
        rep.number = 4'(i);
        if (last_value[i] != held_val) begin
          rep.changed = 1'b1;
          last_value[i] = held_val;
        end
        break;
      end
    end
    reports_due.push_back(rep);
  endtask

  // Advances the header hunt and frame body tracking by one received byte.
  task parse_rx_byte(input logic [7:0] b);
    case (phase)
      PH_HDR1: begin
        if (b == HDR_FIRST) phase = PH_HDR2;
      end
      PH_HDR2: begin
        if (b == HDR_SECOND) phase = PH_LEN;
        else if (b != HDR_FIRST) phase = PH_HDR1;
      end
      PH_LEN: begin
        total = {1'b0, b} + LEN_EXTRA;
        pos = 9'd3;
        held_addr = '0;
        held_val = '0;
        phase = PH_BODY;
        if (pos >= total) close_frame();
      end
      default: begin
        if (pos == ADDR_OFFSET) held_addr = b;
        if (pos == VALUE_OFFSET) held_val = b;
        pos = pos + 9'd1;
        if (pos >= total) close_frame();
      end
    endcase
  endtask

  // Compares one delivered result with the oldest expected report.
  task check_result();
    frame_report_t want;
    if (reports_due.size() == 0) begin
      failure_tally++;
      if (failure_tally <= 10)
        $display("unexpected result: addr %h value %h switch %b num %0d changed %b",
                 frame_address, frame_value, is_switch, switch_number,
                 switch_changed);
    end else begin
      want = reports_due.pop_front();
      if (want.address !== frame_address || want.value !== frame_value ||
          want.is_switch !== is_switch || want.number !== switch_number ||
          want.changed !== switch_changed) begin
        failure_tally++;
        if (failure_tally <= 10)
          $display({"result mismatch: expected addr %h value %h switch %b num %0d ",
                    "changed %b, got addr %h value %h switch %b num %0d changed %b"},
                   want.address, want.value, want.is_switch, want.number,
                   want.changed, frame_address, frame_value, is_switch,
                   switch_number, switch_changed);
      end
    end
  endtask

  // Watch both channels and the register port at every clock edge.
  always @(posedge clk) begin
    if (rst) begin
      phase = PH_HDR1;
      pos = '0;
      total = '0;
      held_addr = '0;
      held_val = '0;
      ignored_addr = IGNORED_RESET;
      for (int i = 0; i < SWITCH_TABLE; i++) last_value[i] = '0;
      reports_due.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_write_enable) ignored_addr = cfg_write_data;
      if (in_valid && in_ready) parse_rx_byte(rx_byte);
    end
    outstanding <= reports_due.size();
    failures <= failure_tally;
  end

endmodule

// File: tb/tb_display_reply_frame_parser_unit.sv
// Testbench top for the display reply frame parser: stimulus, pacing and verdict.
module tb_display_reply_frame_parser_unit;
  import drfp_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_write_enable;
  logic [7:0] cfg_write_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] frame_address;
  logic [7:0] frame_value;
  logic       is_switch;
  logic [3:0] switch_number;
  logic       switch_changed;
  int         outstanding;
  int         failures;

  bit         idle_on;
  int         bytes_sent;
  logic [7:0] ignored_now;

  display_reply_frame_parser_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_address    (frame_address),
    .frame_value      (frame_value),
    .is_switch        (is_switch),
    .switch_number    (switch_number),
    .switch_changed   (switch_changed)
  );

  drfp_reply_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frame_address    (frame_address),
    .frame_value      (frame_value),
    .is_switch        (is_switch),
    .switch_number    (switch_number),
    .switch_changed   (switch_changed),
    .outstanding      (outstanding),
    .failures         (failures)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

  // Idle length: mostly none or short, now and then long, none while pacing is off.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // The result side stalls at random.
  initial begin
    int span;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      span = pick_idle();
      if (span > 0) begin
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Offers one byte, possibly after a gap, and returns once it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends a complete frame with header, length, address and value in place.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] addr,
                            input logic [7:0] val);
    logic [8:0] total;
    logic [8:0] k;
    total = {1'b0, len} + LEN_EXTRA;
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(len);
    for (k = 9'd3; k < total; k++) begin
      if (k == ADDR_OFFSET) send_byte(addr);
      else if (k == VALUE_OFFSET) send_byte(val);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Stops the input, lets all results drain and the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes the ignored address while the block is idle.
  task automatic set_ignored(input logic [7:0] v);
    drain();
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    ignored_now = v;
  endtask

  // Mostly well-formed frames of typical size, with short, long and noisy ones mixed in.
  task automatic random_traffic(input int budget);
    int r;
    logic [7:0] len;
    logic [7:0] addr;
    logic [7:0] val;
    while (bytes_sent < budget) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 9);
      if (r == 5 || r == 6) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (r == 7) begin
        send_byte(HDR_FIRST);
        send_byte(8'($urandom_range(0, 255)));
      end else if (r == 8) begin
        send_byte(HDR_FIRST);
      end
      r = $urandom_range(0, 99);
      if (r < 70) len = 8'($urandom_range(6, 12));
      else if (r < 85) len = 8'($urandom_range(0, 5));
      else if (r < 97) len = 8'($urandom_range(13, 40));
      else len = 8'($urandom_range(200, 255));
      r = $urandom_range(0, 99);
      if (r < 45) addr = SWITCH_ADDR[$urandom_range(0, SWITCH_TABLE - 1)];
      else if (r < 60) addr = ignored_now;
      else if (r < 65) addr = r[0] ? HDR_FIRST : HDR_SECOND;
      else addr = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      val = (r < 40) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
      send_frame(len, addr, val);
    end
  endtask

  // Main sequence: reset, directed frames, then random phases under several settings.
  initial begin
    logic [7:0] settings [4];
    int phase_budget;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    idle_on = 1'b1;
    bytes_sent = 0;
    ignored_now = IGNORED_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Extreme noise bytes, a doubled first header byte with a zero-length frame,
    // a broken header, a short frame, and a full frame on the last switch.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_frame(8'd0, 8'h00, 8'h00);
    send_byte(HDR_FIRST);
    send_byte(8'h33);
    send_frame(8'd5, SWITCH_ADDR[0], 8'h11);
    send_frame(8'd6, SWITCH_ADDR[SWITCH_TABLE - 1], 8'hFF);

    // Random phases, the first one under the reset value of the register.
    settings = '{8'h00, 8'hFF, SWITCH_ADDR[0], 8'($urandom_range(0, 255))};
    phase_budget = 205;
    random_traffic(bytes_sent + phase_budget);
    foreach (settings[i]) begin
      set_ignored(settings[i]);
      random_traffic(bytes_sent + phase_budget);
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/drfp_pkg.sv
sv/drfp_frame_tracker.sv
sv/drfp_switch_table.sv
sv/display_reply_frame_parser_unit.sv
tb/drfp_reply_checker.sv
tb/tb_display_reply_frame_parser_unit.sv
